>>> rtl/core/ppmsd_pkg.sv
// Shared types and constants of the PPM/PGM stream decoder.
// Used by ppmsd_core and ppm_stream_decoder_unit; depends on nothing.

package ppmsd_pkg;

    localparam int unsigned DEFAULT_MAX_DIM = 65535;
    localparam int unsigned MAX_SAMPLE      = 255;

    localparam logic [2:0] CHAN_RESET = 3'd3;
    localparam logic [2:0] CHAN_GRAY  = 3'd1;
    localparam logic [2:0] CHAN_GA    = 3'd2;
    localparam logic [2:0] CHAN_RGBA  = 3'd4;

    localparam logic [1:0] KIND_GEOM  = 2'd0;
    localparam logic [1:0] KIND_PIXEL = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic ERR_HEADER = 1'b0;
    localparam logic ERR_TRUNC  = 1'b1;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    localparam int unsigned LIST_DEPTH = 4;

    typedef enum logic [6:0] {
        PH_MAGIC0 = 7'b0000001,
        PH_MAGIC1 = 7'b0000010,
        PH_WIDTH  = 7'b0000100,
        PH_HEIGHT = 7'b0001000,
        PH_MAXV   = 7'b0010000,
        PH_PIXELS = 7'b0100000,
        PH_DONE   = 7'b1000000
    } ppmsd_phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] width;
        logic [15:0] height;
        logic        err_code;
        logic        last_image;
        logic        last_run;
    } ppmsd_item_t;

    typedef struct packed {
        logic [2:0]             count;
        ppmsd_item_t [3:0]      items;
    } ppmsd_list_t;

endpackage

>>> rtl/core/ppmsd_core.sv
// Header parser and pixel expander: holds the parse state and turns one file
// byte into a list of up to four result words. Depends on ppmsd_pkg.

module ppmsd_core #(
    parameter int unsigned MAX_DIM = ppmsd_pkg::DEFAULT_MAX_DIM
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  logic [7:0]            byte_in,
    input  logic                  eof_in,
    input  logic [2:0]            chan_cnt,
    output ppmsd_pkg::ppmsd_list_t res_list
);
    import ppmsd_pkg::*;

    localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
    localparam int unsigned ACC_W = $clog2(MAX_DIM + 257);
    localparam int unsigned PIX_W = 2 * DIM_W;
    localparam logic [ACC_W-1:0] NUM_CAP = ACC_W'(MAX_DIM + 256);
    localparam logic [ACC_W-1:0] DIM_MAX = ACC_W'(MAX_DIM);

    ppmsd_phase_t     phase_reg, phase_next;
    logic             rgb_reg, rgb_next;
    logic             comment_reg, comment_next;
    logic             digit_reg, digit_next;
    logic [ACC_W-1:0] accum_reg, accum_next;
    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic [PIX_W-1:0] pix_left_reg, pix_left_next;
    logic [1:0]       comp_idx_reg, comp_idx_next;

    logic             is_space, is_digit;
    logic [7:0]       dig_sub;
    logic [3:0]       digit_val;
    logic [ACC_W+3:0] accum_mul;
    logic [ACC_W-1:0] accum_sat;
    logic [PIX_W-1:0] geom_area;
    logic [PIX_W-1:0] pix_dec;
    logic [DIM_W+15:0] width_ext, height_ext;
    logic             pl_one, last_byte, last_emit, completes;
    logic [1:0]       n_copy;
    logic [2:0]       k_emit;
    logic             start_scan, hdr_err;
    logic [2:0]       n_res;

    assign is_space  = (byte_in == CH_SPACE) || (byte_in >= CH_TAB && byte_in <= CH_CR);
    assign is_digit  = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
    assign dig_sub   = byte_in - CH_ZERO;
    assign digit_val = dig_sub[3:0];
    assign accum_mul = (ACC_W+4)'({accum_reg, 3'b000}) + (ACC_W+4)'({accum_reg, 1'b0})
                     + (ACC_W+4)'(digit_val);
    assign accum_sat = (accum_mul > (ACC_W+4)'(NUM_CAP)) ? NUM_CAP : accum_mul[ACC_W-1:0];
    assign geom_area = PIX_W'(width_reg) * PIX_W'(height_reg);
    assign pix_dec   = pix_left_reg - PIX_W'(pix_left_reg != '0);
    assign width_ext  = {16'b0, width_reg};
    assign height_ext = {16'b0, height_reg};

    // Pixel expansion shape: n_copy source copies, then opaque fill up to k_emit.
    always_comb begin
        pl_one = (pix_left_reg == PIX_W'(1));
        if (rgb_reg) begin
            last_byte = (comp_idx_reg >= 2'd2);
            if (chan_cnt <= CHAN_GA) begin
                n_copy    = (comp_idx_reg == 2'd0) ? 2'd1 : 2'd0;
                k_emit    = (comp_idx_reg == 2'd0) ? chan_cnt : 3'd0;
                last_emit = (comp_idx_reg == 2'd0);
            end else begin
                n_copy    = 2'd1;
                k_emit    = (chan_cnt == CHAN_RGBA && last_byte) ? 3'd2 : 3'd1;
                last_emit = last_byte;
            end
        end else begin
            last_byte = 1'b1;
            last_emit = 1'b1;
            n_copy    = (chan_cnt <= CHAN_GA) ? 2'd1 : 2'd3;
            k_emit    = chan_cnt;
        end
        completes = last_byte && pl_one;
    end

    always_comb begin
        phase_next    = phase_reg;
        rgb_next      = rgb_reg;
        comment_next  = comment_reg;
        digit_next    = digit_reg;
        accum_next    = accum_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        pix_left_next = pix_left_reg;
        comp_idx_next = comp_idx_reg;
        start_scan    = 1'b0;
        hdr_err       = 1'b0;
        n_res         = 3'd0;
        res_list      = '0;

        unique case (phase_reg) inside
            PH_MAGIC0: begin
                phase_next = PH_MAGIC1;
            end
            PH_MAGIC1: begin
                rgb_next     = (byte_in == CH_SIX);
                phase_next   = PH_WIDTH;
                comment_next = 1'b0;
                digit_next   = 1'b0;
            end
            PH_WIDTH, PH_HEIGHT, PH_MAXV: begin
                if (!digit_reg) begin
                    start_scan = 1'b1;
                end else if (is_digit) begin
                    accum_next = accum_sat;
                end else begin
                    // number ends on this byte
                    digit_next = 1'b0;
                    accum_next = '0;
                    if (phase_reg == PH_MAXV) begin
                        if (accum_reg != ACC_W'(MAX_SAMPLE) || !is_space) begin
                            hdr_err = 1'b1;
                        end else begin
                            res_list.items[0].kind   = KIND_GEOM;
                            res_list.items[0].width  = width_ext[15:0];
                            res_list.items[0].height = height_ext[15:0];
                            n_res         = 3'd1;
                            pix_left_next = geom_area;
                            comp_idx_next = 2'd0;
                            phase_next    = PH_PIXELS;
                        end
                    end else if (accum_reg == '0 || accum_reg > DIM_MAX) begin
                        hdr_err = 1'b1;
                    end else begin
                        if (phase_reg == PH_WIDTH) begin
                            width_next = accum_reg[DIM_W-1:0];
                            phase_next = PH_HEIGHT;
                        end else begin
                            height_next = accum_reg[DIM_W-1:0];
                            phase_next  = PH_MAXV;
                        end
                        start_scan = 1'b1;
                    end
                end
                if (start_scan) begin
                    if (comment_reg) begin
                        if (byte_in == CH_LF) begin
                            comment_next = 1'b0;
                        end
                    end else if (byte_in == CH_HASH) begin
                        comment_next = 1'b1;
                    end else if (is_digit) begin
                        digit_next = 1'b1;
                        accum_next = ACC_W'(digit_val);
                    end else if (!is_space) begin
                        hdr_err = 1'b1;
                    end
                end
                if (hdr_err) begin
                    res_list.items[0].kind       = KIND_ERROR;
                    res_list.items[0].err_code   = ERR_HEADER;
                    res_list.items[0].last_image = 1'b1;
                    n_res      = 3'd1;
                    phase_next = PH_DONE;
                end
            end
            PH_PIXELS: begin
                // a final byte that leaves the image short is dropped
                if (!(eof_in && !completes)) begin
                    for (int i = 0; i < LIST_DEPTH; i++) begin
                        if (3'(i) < k_emit) begin
                            res_list.items[i].kind = KIND_PIXEL;
                            res_list.items[i].data = (3'(i) < {1'b0, n_copy}) ?
                                                     byte_in : ALPHA_OPAQUE;
                            res_list.items[i].last_image =
                                (3'(i) == k_emit - 3'd1) && last_emit && pl_one;
                        end
                    end
                    n_res = k_emit;
                    if (last_byte) begin
                        comp_idx_next = 2'd0;
                        pix_left_next = pix_dec;
                        if (pix_dec == '0) begin
                            phase_next = PH_DONE;
                        end
                    end else begin
                        comp_idx_next = comp_idx_reg + 2'd1;
                    end
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        if (eof_in) begin
            if (n_res < 3'(LIST_DEPTH) && phase_next != PH_DONE) begin
                res_list.items[n_res[1:0]].kind       = KIND_ERROR;
                res_list.items[n_res[1:0]].err_code   =
                    (phase_next == PH_PIXELS) ? ERR_TRUNC : ERR_HEADER;
                res_list.items[n_res[1:0]].last_image = 1'b1;
                n_res = n_res + 3'd1;
            end
            phase_next    = PH_MAGIC0;
            rgb_next      = 1'b0;
            comment_next  = 1'b0;
            digit_next    = 1'b0;
            accum_next    = '0;
            width_next    = '0;
            height_next   = '0;
            pix_left_next = '0;
            comp_idx_next = 2'd0;
        end

        if (n_res != 3'd0) begin
            res_list.items[2'(n_res - 3'd1)].last_run = 1'b1;
        end
        res_list.count = n_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_MAGIC0;
            rgb_reg      <= 1'b0;
            comment_reg  <= 1'b0;
            digit_reg    <= 1'b0;
            accum_reg    <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            pix_left_reg <= '0;
            comp_idx_reg <= 2'd0;
        end else if (step_en) begin
            phase_reg    <= phase_next;
            rgb_reg      <= rgb_next;
            comment_reg  <= comment_next;
            digit_reg    <= digit_next;
            accum_reg    <= accum_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            pix_left_reg <= pix_left_next;
            comp_idx_reg <= comp_idx_next;
        end
    end

`ifndef ASSERT_OFF
    a_pixels_have_area: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PIXELS |-> pix_left_reg != '0)
        else $error("pixel phase entered with no pixels left");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        res_list.count <= 3'(LIST_DEPTH))
        else $error("result list overflow");
    a_eof_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && eof_in |=> phase_reg == PH_MAGIC0 && pix_left_reg == '0)
        else $error("parser did not restart after end of file");
`endif

endmodule

>>> rtl/core/ppm_stream_decoder_unit.sv
// Top level of the binary PPM/PGM stream decoder: input word register,
// channel-count register, result queue. Depends on ppmsd_pkg and ppmsd_core.
// An accepted input word passes the input word register and then the result queue;
// throughput: one file byte per cycle while each byte gives at most one word and
//   m_tready is high; a byte giving more words (channel expansion) holds the next byte
//   until the four-slot result queue, draining one word per cycle while m_tready is high, is down to its last word.
// Reset: synchronous, active low; parser returns to the first magic byte and
//   the channel count to 3 (rgb). No clearing pass.

module ppm_stream_decoder_unit #(
    parameter int unsigned MAX_DIM = ppmsd_pkg::DEFAULT_MAX_DIM
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,   // channels per output pixel

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] in_byte
    input  logic        s_tlast,       // end_of_file

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,       // [7:0] out_byte, [23:8] image_width,
                                       // [39:24] image_height, [40] error_code,
                                       // [41] last_of_image, [47:42] zero
    output logic [1:0]  m_tuser,       // [1:0] out_kind
    output logic        m_tlast        // last_of_run
);
    import ppmsd_pkg::*;

    // Input word register: one file byte waiting for the parser.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_eof_reg;

    // Channel count, kept saturated to 1..4 so the core never sees 0 or >4.
    logic [2:0]  chan_reg;

    // Result queue: slot 0 drives the master port, later slots shift down.
    logic [2:0]        q_cnt_reg;
    ppmsd_item_t [3:0] q_item_reg;

    ppmsd_list_t res_list;
    logic        m_fire;
    logic        q_room;
    logic        step_fire;

    assign m_tvalid = (q_cnt_reg != 3'd0);
    assign m_fire   = m_tvalid && m_tready;
    // Queue can take a new list once it is empty or its last word leaves now.
    assign q_room    = (q_cnt_reg == 3'd0) || (q_cnt_reg == 3'd1 && m_tready);
    assign step_fire = in_valid_reg && q_room;
    // Take a new byte whenever the register is empty or the held one is consumed this cycle.
    assign s_tready  = !in_valid_reg || step_fire;

    ppmsd_core #(
        .MAX_DIM (MAX_DIM)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (step_fire),
        .byte_in  (in_byte_reg),
        .eof_in   (in_eof_reg),
        .chan_cnt (chan_reg),
        .res_list (res_list)
    );

    // Control: input valid, queue fill, channel register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            q_cnt_reg    <= 3'd0;
            chan_reg     <= CHAN_RESET;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (step_fire) begin
                q_cnt_reg <= res_list.count;
            end else if (m_fire) begin
                q_cnt_reg <= q_cnt_reg - 3'd1;
            end
            if (cfg_wr_en) begin
                if (cfg_wr_data < CHAN_GRAY) begin
                    chan_reg <= CHAN_GRAY;
                end else if (cfg_wr_data > CHAN_RGBA) begin
                    chan_reg <= CHAN_RGBA;
                end else begin
                    chan_reg <= cfg_wr_data;
                end
            end
        end
    end

    // Payload: capture the byte on accept, load or shift the queue.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_eof_reg  <= s_tlast;
        end
        if (step_fire) begin
            q_item_reg <= res_list.items;
        end else if (m_fire) begin
            q_item_reg[0] <= q_item_reg[1];
            q_item_reg[1] <= q_item_reg[2];
            q_item_reg[2] <= q_item_reg[3];
        end
    end

    assign m_tdata = {6'b0,
                      q_item_reg[0].last_image,
                      q_item_reg[0].err_code,
                      q_item_reg[0].height,
                      q_item_reg[0].width,
                      q_item_reg[0].data};
    assign m_tuser = q_item_reg[0].kind;
    assign m_tlast = q_item_reg[0].last_run;

`ifndef ASSERT_OFF
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !in_valid_reg)
        else $error("queue or input register not empty after reset");
    a_tail_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && q_cnt_reg == 3'd1 |-> m_tlast)
        else $error("last queued word does not close its run");
    a_error_ends_image: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_ERROR |-> m_tdata[41] && m_tdata[39:0] == '0)
        else $error("error word malformed");
    a_chan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        chan_reg != 3'd0 && chan_reg <= CHAN_RGBA)
        else $error("channel count out of range");
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_cnt_reg > 3'd1 |-> !step_fire)
        else $error("queue reloaded while words remain");
`endif

endmodule

>>> dv/ppm_stream_decoder_unit_checker.sv
// Checker for the PPM/PGM stream decoder: watches both streams, predicts the result words.
// Compares each result word with the oldest prediction. Depends on ppmsd_pkg only.

module ppm_stream_decoder_unit_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending,
    output int          words_checked,
    output int          geom_words,
    output int          error_words
);
    import ppmsd_pkg::*;

    localparam int unsigned MAX_DIM      = DEFAULT_MAX_DIM;
    localparam int unsigned NUM_CAP      = MAX_DIM + 256;
    localparam int          REPORT_LIMIT = 10;

    // Parser state, mirrored from the file format rules.
    ppmsd_phase_t ph;
    logic         src_rgb;
    logic         in_cmt;
    logic         have_dig;
    logic [16:0]  num_acc;
    logic [15:0]  wid_r;
    logic [15:0]  hgt_r;
    logic [31:0]  px_left;
    logic [1:0]   comp_idx;
    logic [2:0]   chans;

    ppmsd_item_t  byte_words[$];
    ppmsd_item_t  expected_words[$];

    initial begin
        fail_count    = 0;
        pending       = 0;
        words_checked = 0;
        geom_words    = 0;
        error_words   = 0;
    end

    function automatic bit is_ws(logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic bit is_dec(logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic ppmsd_item_t mk_word(logic [1:0] kind, logic [7:0] data,
                                            logic [15:0] w, logic [15:0] h,
                                            logic code, logic loi);
        ppmsd_item_t x;
        x.kind       = kind;
        x.data       = data;
        x.width      = w;
        x.height     = h;
        x.err_code   = code;
        x.last_image = loi;
        x.last_run   = 1'b0;
        return x;
    endfunction

    function automatic string word_text(ppmsd_item_t x);
        return $sformatf("kind=%0d byte=%02h w=%0d h=%0d err=%0d last_img=%0d last_run=%0d",
                         x.kind, x.data, x.width, x.height, x.err_code, x.last_image,
                         x.last_run);
    endfunction

    // One byte never yields more than four words.
    task automatic add_word(ppmsd_item_t x);
        if (byte_words.size() < LIST_DEPTH) byte_words = {byte_words, x};
    endtask

    task automatic restart_parser();
        ph       = PH_MAGIC0;
        src_rgb  = 1'b0;
        in_cmt   = 1'b0;
        have_dig = 1'b0;
        num_acc  = '0;
        wid_r    = '0;
        hgt_r    = '0;
        px_left  = '0;
        comp_idx = '0;
    endtask

    task automatic header_fail();
        add_word(mk_word(KIND_ERROR, 8'd0, 16'd0, 16'd0, ERR_HEADER, 1'b1));
        ph = PH_DONE;
    endtask

    // Byte in a number field while no digit is pending.
    task automatic skip_or_start(logic [7:0] b);
        if (in_cmt) begin
            if (b == CH_LF) in_cmt = 1'b0;
        end else if (b == CH_HASH) begin
            in_cmt = 1'b1;
        end else if (is_ws(b)) begin
            // whitespace between fields: nothing to do
        end else if (is_dec(b)) begin
            have_dig = 1'b1;
            num_acc  = 17'(b - CH_ZERO);
        end else begin
            header_fail();
        end
    endtask

    task automatic number_byte(logic [7:0] b);
        int unsigned v;
        if (!have_dig) begin
            skip_or_start(b);
        end else if (is_dec(b)) begin
            v       = num_acc * 10 + (b - CH_ZERO);
            num_acc = 17'((v > NUM_CAP) ? NUM_CAP : v);
        end else begin
            v        = 32'(num_acc);
            have_dig = 1'b0;
            num_acc  = '0;
            if (ph == PH_MAXV) begin
                // the maximum must be 255 and end on exactly one whitespace byte
                if (v != MAX_SAMPLE || !is_ws(b)) begin
                    header_fail();
                end else begin
                    add_word(mk_word(KIND_GEOM, 8'd0, wid_r, hgt_r, 1'b0, 1'b0));
                    px_left  = 32'(wid_r) * 32'(hgt_r);
                    comp_idx = '0;
                    ph       = PH_PIXELS;
                end
            end else if (v == 0 || v > MAX_DIM) begin
                header_fail();
            end else begin
                if (ph == PH_WIDTH) begin
                    wid_r = 16'(v);
                    ph    = PH_HEIGHT;
                end else begin
                    hgt_r = 16'(v);
                    ph    = PH_MAXV;
                end
                skip_or_start(b);
            end
        end
    endtask

    task automatic pixel_byte(logic [7:0] b, logic eof);
        logic [7:0] vals [4];
        int         k;
        bit         last_byte;
        bit         last_emit;
        bit         completes;
        k = 0;
        if (src_rgb) begin
            last_byte = comp_idx >= 2;
            if (chans <= CHAN_GA) begin
                // gray out of rgb: keep the first byte of each pixel only
                if (comp_idx == 0) begin
                    vals[k] = b;
                    k++;
                    if (chans == CHAN_GA) begin
                        vals[k] = ALPHA_OPAQUE;
                        k++;
                    end
                end
                last_emit = comp_idx == 0;
            end else begin
                vals[k] = b;
                k++;
                if (chans == CHAN_RGBA && last_byte) begin
                    vals[k] = ALPHA_OPAQUE;
                    k++;
                end
                last_emit = last_byte;
            end
        end else begin
            last_byte = 1'b1;
            last_emit = 1'b1;
            vals[0]   = b;
            k         = 1;
            if (chans == CHAN_GA) begin
                vals[1] = ALPHA_OPAQUE;
                k       = 2;
            end else if (chans > CHAN_GA) begin
                vals[1] = b;
                vals[2] = b;
                k       = 3;
                if (chans == CHAN_RGBA) begin
                    vals[3] = ALPHA_OPAQUE;
                    k       = 4;
                end
            end
        end
        completes = last_byte && px_left == 1;
        // drop an end-of-file byte that leaves the image incomplete
        if (!(eof && !completes)) begin
            for (int i = 0; i < k; i++)
                add_word(mk_word(KIND_PIXEL, vals[i], 16'd0, 16'd0, 1'b0,
                                 i == k - 1 && last_emit && px_left == 1));
            if (last_byte) begin
                comp_idx = '0;
                if (px_left > 0) px_left--;
                if (px_left == 0) ph = PH_DONE;
            end else begin
                comp_idx = comp_idx + 2'd1;
            end
        end
    endtask

    task automatic decode_byte(logic [7:0] b, logic eof);
        ppmsd_item_t w;
        byte_words.delete();
        case (ph)
            PH_MAGIC0: ph = PH_MAGIC1;
            PH_MAGIC1: begin
                src_rgb  = (b == CH_SIX);
                ph       = PH_WIDTH;
                in_cmt   = 1'b0;
                have_dig = 1'b0;
            end
            PH_WIDTH, PH_HEIGHT, PH_MAXV: number_byte(b);
            PH_PIXELS: pixel_byte(b, eof);
            default: ;
        endcase
        if (eof) begin
            if (ph == PH_PIXELS)
                add_word(mk_word(KIND_ERROR, 8'd0, 16'd0, 16'd0, ERR_TRUNC, 1'b1));
            else if (ph != PH_DONE)
                add_word(mk_word(KIND_ERROR, 8'd0, 16'd0, 16'd0, ERR_HEADER, 1'b1));
            restart_parser();
        end
        // flag the final word of this byte's run
        for (int i = 0; i < byte_words.size(); i++) begin
            w              = byte_words[i];
            w.last_run     = (i == byte_words.size() - 1);
            expected_words = {expected_words, w};
        end
    endtask

    task automatic check_word();
        ppmsd_item_t got;
        ppmsd_item_t want;
        got.kind       = m_tuser;
        got.data       = m_tdata[7:0];
        got.width      = m_tdata[23:8];
        got.height     = m_tdata[39:24];
        got.err_code   = m_tdata[40];
        got.last_image = m_tdata[41];
        got.last_run   = m_tlast;
        words_checked++;
        if (got.kind == KIND_GEOM) geom_words++;
        if (got.kind == KIND_ERROR) error_words++;
        if (expected_words.size() == 0) begin
            if (fail_count < REPORT_LIMIT)
                $display("checker: unexpected word %s", word_text(got));
            fail_count++;
        end else begin
            want = expected_words.pop_front();
            if (got !== want || m_tdata[47:42] !== 6'd0) begin
                if (fail_count < REPORT_LIMIT) begin
                    $display("checker: word %0d expected %s", words_checked, word_text(want));
                    $display("checker: word %0d actual   %s pad=%02h", words_checked,
                             word_text(got), m_tdata[47:42]);
                end
                fail_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            chans = CHAN_RESET;
            restart_parser();
            expected_words.delete();
        end else begin
            // out-of-range channel counts clamp to 1 or 4
            if (cfg_wr_en)
                chans = (cfg_wr_data < CHAN_GRAY) ? CHAN_GRAY :
                        (cfg_wr_data > CHAN_RGBA) ? CHAN_RGBA : cfg_wr_data;
            if (m_tvalid && m_tready) check_word();
            if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
        end
        pending = expected_words.size();
    end

endmodule

>>> dv/ppm_stream_decoder_unit_tb.sv
// Testbench top for ppm_stream_decoder_unit: clock, reset, file stimulus and verdict.
// Depends on ppmsd_pkg, the decoder RTL and ppm_stream_decoder_unit_checker.

module ppm_stream_decoder_unit_tb;
    import ppmsd_pkg::*;

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         SETTLE_CYCLES  = 6;
    localparam int         RANDOM_BYTES   = 170;
    localparam logic [2:0] CHAN_BELOW     = 3'd0;   // clamps to gray
    localparam logic [2:0] CHAN_ABOVE     = 3'd7;   // clamps to rgba
    localparam logic [7:0] CH_P           = 8'h50;
    localparam logic [7:0] CH_FIVE        = 8'h35;
    localparam logic [7:0] CH_VT          = 8'h0B;
    localparam logic [7:0] CH_FORMFEED    = 8'h0C;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int fail_count;
    int pending;
    int words_checked;
    int geom_words;
    int error_words;

    int files_sent;
    int bytes_sent;
    int random_bytes;
    int cfg_writes;
    int quiet_cycles;

    // Bytes of the file under construction; the last one goes out with tlast.
    logic [7:0] file_bytes[$];

    ppm_stream_decoder_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    ppm_stream_decoder_unit_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked),
        .geom_words    (geom_words),
        .error_words   (error_words)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Idle cycles before a word; a calm stretch sends back to back.
    function automatic int draw_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    // Offer one word at the falling edge and hold it until it is taken.
    task automatic put_byte(logic [7:0] b, logic eof, bit calm);
        int gap;
        gap = draw_gap(calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eof;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_file();
        bit calm;
        calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < file_bytes.size(); i++)
            put_byte(file_bytes[i], i == file_bytes.size() - 1, calm);
        files_sent++;
        bytes_sent += file_bytes.size();
    endtask

    // Append one byte to the file under construction.
    task automatic add_byte(logic [7:0] b);
        file_bytes = {file_bytes, b};
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic start_file(string s);
        file_bytes.delete();
        add_text(s);
    endtask

    task automatic send_text(string s);
        start_file(s);
        send_file();
    endtask

    // Decimal number, now and then with leading zeros.
    task automatic add_num(int unsigned n);
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
            add_byte(CH_ZERO);
        add_text($sformatf("%0d", n));
    endtask

    // Run of whitespace bytes and comments between header fields.
    task automatic add_sep(int min_pieces);
        logic [7:0] c;
        repeat ($urandom_range(min_pieces, min_pieces + 2)) begin
            if ($urandom_range(0, 3) == 0) begin
                add_byte(CH_HASH);
                repeat ($urandom_range(0, 5)) begin
                    c = 8'($urandom_range(0, 255));
                    add_byte(c == CH_LF ? CH_HASH : c);
                end
                add_byte(CH_LF);
            end else begin
                case ($urandom_range(0, 5))
                    0: add_byte(CH_SPACE);
                    1: add_byte(CH_TAB);
                    2: add_byte(CH_LF);
                    3: add_byte(CH_VT);
                    4: add_byte(CH_FORMFEED);
                    default: add_byte(CH_CR);
                endcase
            end
        end
    endtask

    // A byte that is neither digit, whitespace nor comment start.
    function automatic logic [7:0] junk_byte();
        return $urandom_range(0, 1) ? 8'($urandom_range(0, 8))
                                    : 8'($urandom_range(8'h3A, 8'hFF));
    endfunction

    task automatic build_random_file();
        int          flaw;
        bit          rgb;
        int unsigned w;
        int unsigned h;
        int unsigned maxv;
        int unsigned npix;
        logic [7:0]  magic;
        file_bytes.delete();
        flaw = $urandom_range(0, 15);
        rgb  = 1'($urandom_range(0, 1));
        w    = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        h    = $urandom_range(1, 3);
        maxv = MAX_SAMPLE;
        case (flaw)
            0: if ($urandom_range(0, 1)) w = 0; else h = 0;
            1: case ($urandom_range(0, 2))
                   0: w = DEFAULT_MAX_DIM;
                   1: h = DEFAULT_MAX_DIM + $urandom_range(1, 5000);
                   default: w = $urandom_range(100000, 99999999);
               endcase
            2: begin
                maxv = $urandom_range(0, 999);
                if (maxv == MAX_SAMPLE) maxv = 0;
            end
            default: ;
        endcase
        add_byte($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : CH_P);
        if (!rgb && $urandom_range(0, 3) == 0) begin
            magic = 8'($urandom_range(0, 255));
            rgb   = (magic == CH_SIX);
        end else begin
            magic = rgb ? CH_SIX : CH_FIVE;
        end
        add_byte(magic);
        add_sep(0);
        if (flaw == 3) add_byte(junk_byte());
        add_num(w);
        add_sep(1);
        add_num(h);
        add_sep(1);
        add_num(maxv);
        add_byte(flaw == 4 ? junk_byte() : CH_LF);
        npix = w * h * (rgb ? 3 : 1);
        // huge geometry: send a few pixels and let the file end short
        if (w > 64 || h > 64) npix = $urandom_range(1, 6);
        repeat (npix) add_byte(8'($urandom_range(0, 255)));
        if (flaw == 6) repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
        if (flaw == 5 && file_bytes.size() > 1)
            repeat ($urandom_range(1, file_bytes.size() - 1)) void'(file_bytes.pop_back());
    endtask

    // Drain the decoder, then write the channel count.
    task automatic set_channels(logic [2:0] value);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        cfg_writes++;
    endtask

    // Result side: stall a random number of cycles before each word.
    initial begin : receiver
        int stall;
        bit calm;
        m_tready = 1'b0;
        calm     = 1'b0;
        @(negedge aclk);
        forever begin
            stall = draw_gap(calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
            if ($urandom_range(0, 24) == 0) calm = !calm;
        end
    end

    // Abort when neither stream moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d words pending",
                     WATCHDOG_LIMIT, pending);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int files_left;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = CHAN_RESET;
        s_tvalid     = 1'b0;
        s_tdata      = 8'd0;
        s_tlast      = 1'b0;
        files_sent   = 0;
        bytes_sent   = 0;
        random_bytes = 0;
        cfg_writes   = 0;
        quiet_cycles = 0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed files. Reset channel count (rgb) first: rgb and gray sources,
        // extreme pixel values.
        start_file("P6 2 1 255\n");
        add_byte(8'h00); add_byte(8'hFF); add_byte(8'h80);
        add_byte(8'h01); add_byte(8'h7F); add_byte(8'hFE);
        send_file();
        start_file("P5\0111 2\015255 ");
        add_byte(8'h00); add_byte(8'hFF);
        send_file();

        // rgba: comments around every field, trailing bytes after the image
        set_channels(CHAN_RGBA);
        start_file("P6#c\n1#w\n1\n#m\n255\n");
        add_byte(8'h12); add_byte(8'h34); add_byte(8'h56);
        add_byte(8'hAA); add_byte(8'h55);
        send_file();
        // file ends one pixel short: the last byte is dropped, truncation reported
        start_file("P5 2 1 255\n");
        add_byte(8'hAB);
        send_file();

        // gray: largest geometry, cut short
        set_channels(CHAN_GRAY);
        start_file("P6 1 1 255\n");
        add_byte(8'hC3); add_byte(8'h3C); add_byte(8'h99);
        send_file();
        start_file("P5 65535 65535 255\n");
        add_byte(8'h01); add_byte(8'h02); add_byte(8'h03);
        send_file();

        // gray+alpha: header problems and end of file inside or right after the header
        set_channels(CHAN_GA);
        send_text("P5 1 1 255\n");
        send_text("P");
        send_text("P6");
        send_text("P5 0 1 255\nxyz");
        send_text("P5 1 65536 255\n");
        send_text("P5 9999999 1 255\n");
        send_text("P5 1 1 254\n");
        send_text("P5 1 1 255#");
        send_text("P5 x1");
        send_text("P5 #abc");
        start_file("P5 1 1 255\t");
        add_byte(8'h5A);
        send_file();

        // out-of-range channel counts
        set_channels(CHAN_BELOW);
        start_file("P5 1 1 255\n");
        add_byte(8'hFF);
        send_file();
        set_channels(CHAN_ABOVE);
        start_file("P6 1 1 255\n");
        add_byte(8'h80); add_byte(8'h40); add_byte(8'h20);
        send_file();

        // Random files, mostly well formed, with a new channel count every few files.
        files_left = 0;
        while (random_bytes < RANDOM_BYTES) begin
            if (files_left == 0) begin
                set_channels(3'($urandom_range(0, 7)));
                files_left = $urandom_range(3, 6);
            end
            build_random_file();
            random_bytes += file_bytes.size();
            send_file();
            files_left--;
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("Ran %0d files, %0d bytes (%0d random) under %0d channel-count writes",
                 files_sent, bytes_sent, random_bytes, cfg_writes);
        $display("Checked %0d result words: %0d geometry, %0d error; %0d mismatches",
                 words_checked, geom_words, error_words, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
